@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
// Depends on nothing; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
// Assertion checked only outside reset.
`define ASSERT_RUN(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`endif

@@ hdl/weno3_pkg.sv @@
// Constants, widths and the divider stage type of the WENO3 face reconstruction.
// Depends on nothing.
`timescale 1ns / 1ps
package weno3_pkg;
  localparam int FRAC_BITS = 16;
  localparam int IN_W = 32;
  localparam int EPS_W = 32;
  localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;
  localparam int W_BITS = 29;
  localparam int MANT_BITS = 30;
  localparam int UNIT = (2 * FRAC_BITS > EPS_W) ? 2 * FRAC_BITS : EPS_W;
  localparam int SQ_SH = UNIT - 2 * FRAC_BITS;
  localparam int EPS_SH = UNIT - EPS_W;
  localparam int DIFF_W = IN_W + 1;
  localparam int MAG_W = DIFF_W;
  localparam int SQ_W = 2 * MAG_W;
  localparam int D_W = SQ_W + SQ_SH + 1;
  localparam int LEN_W = $clog2(D_W + 1);
  localparam int NUM_W = 2 * MANT_BITS;
  localparam int DEN_W = NUM_W + 2;
  localparam int Q_W = W_BITS + 2;
  localparam int STEPS = W_BITS + 1;
  localparam int WT_W = W_BITS + 1;
  localparam logic [WT_W-1:0] W_ONE_THIRD = WT_W'((((64'd1 << (W_BITS + 1)) / 3) + 1) >> 1);
  localparam int S_W = IN_W + 1;
  localparam int T_W = IN_W + 3;
  localparam int PROD_W = WT_W + 1 + T_W;
  localparam int X_W = PROD_W + 2;

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic [DEN_W-1:0]        r;
    logic [DEN_W-1:0]        den;
    logic [Q_W-1:0]          q;
    logic signed [S_W-1:0]   s;
    logic signed [T_W-1:0]   t;
  } div_stage_t;
endpackage

@@ hdl/weno3_face_reconstruction.sv @@
// Top level of the WENO3 face reconstruction pipeline.
// Depends on weno3_pkg and weno3_div_cell.
`timescale 1ns / 1ps
// One stencil is taken per cycle while the skid entry is empty, and its face value
// leaves through a pipeline whose longest part is a chain of 30 divider cells,
// each producing one quotient bit of the weight. An output register with a skid
// entry lets a new transfer be taken while a result waits; epsilon may be
// written at any idle time and applies to the stencils taken afterwards.
module weno3_face_reconstruction (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [weno3_pkg::EPS_W-1:0]            epsilon,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [weno3_pkg::IN_W-1:0]      f_left,
  input  logic signed [weno3_pkg::IN_W-1:0]      f_center,
  input  logic signed [weno3_pkg::IN_W-1:0]      f_right,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [weno3_pkg::IN_W-1:0]      fhat
);
  localparam int DW = weno3_pkg::D_W;
  localparam int MW = weno3_pkg::MANT_BITS;
  localparam int SW = weno3_pkg::S_W;
  localparam int TW = weno3_pkg::T_W;

  logic [weno3_pkg::EPS_W-1:0] eps;
  logic adv;
  logic skid_valid;
  logic signed [weno3_pkg::IN_W-1:0] skid_data;

  logic signed [weno3_pkg::DIFF_W-1:0] a_diff, b_diff;
  logic v1, v2, v3, v4, v5, v6, v7, v8, vw, vm;
  logic [weno3_pkg::MAG_W-1:0] a_mag, b_mag;
  logic [weno3_pkg::SQ_W-1:0] sq0, sq1;
  logic [DW-1:0] d0_3, d1_3, d0_4, d1_4, big4, d0_5, d1_5;
  logic [weno3_pkg::LEN_W-1:0] len_c, k_c, k5;
  logic [MW-1:0] m0, m1;
  logic [weno3_pkg::NUM_W-1:0] num7, m0sq7, num8;
  logic [weno3_pkg::DEN_W-1:0] den8;
  logic signed [SW-1:0] s1, s2, s3, s4, s5, s6, s7, s8, sw, sm;
  logic signed [TW-1:0] t1, t2, t3, t4, t5, t6, t7, t8, tw;
  logic [weno3_pkg::WT_W-1:0] w_reg;
  logic signed [weno3_pkg::PROD_W-1:0] prod;
  logic signed [weno3_pkg::X_W-1:0] x_sum, q_sh;
  logic signed [weno3_pkg::IN_W-1:0] res;
  logic [weno3_pkg::Q_W-1:0] q_inc;
  logic prep_ge;
  weno3_pkg::div_stage_t chain [0:weno3_pkg::STEPS];

  assign cfg_ready = 1'b1;
  assign adv = !skid_valid;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= weno3_pkg::EPS_RESET;
    end else if (cfg_valid) begin
      eps <= epsilon;
    end
  end

  assign a_diff = weno3_pkg::DIFF_W'(f_center) - weno3_pkg::DIFF_W'(f_left);
  assign b_diff = weno3_pkg::DIFF_W'(f_right) - weno3_pkg::DIFF_W'(f_center);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; vw <= 1'b0; vm <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; vw <= chain[weno3_pkg::STEPS].valid; vm <= vw;
    end
  end

  always_comb begin
    len_c = '0;
    for (int i = 0; i < DW; i++) begin
      if (big4[i]) begin
        len_c = weno3_pkg::LEN_W'(i + 1);
      end
    end
    k_c = (len_c > weno3_pkg::LEN_W'(MW)) ? len_c - weno3_pkg::LEN_W'(MW) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag <= a_diff[weno3_pkg::DIFF_W-1] ? weno3_pkg::MAG_W'(-a_diff)
                                           : weno3_pkg::MAG_W'(a_diff);
      b_mag <= b_diff[weno3_pkg::DIFF_W-1] ? weno3_pkg::MAG_W'(-b_diff)
                                           : weno3_pkg::MAG_W'(b_diff);
      s1 <= SW'(f_center) + SW'(f_right);
      t1 <= TW'(f_center) + TW'(f_center) - TW'(f_left) - TW'(f_right);
      sq0 <= a_mag * a_mag;
      sq1 <= b_mag * b_mag;
      s2 <= s1; t2 <= t1;
      d0_3 <= (DW'(sq0) << weno3_pkg::SQ_SH) + (DW'(eps) << weno3_pkg::EPS_SH);
      d1_3 <= (DW'(sq1) << weno3_pkg::SQ_SH) + (DW'(eps) << weno3_pkg::EPS_SH);
      s3 <= s2; t3 <= t2;
      d0_4 <= d0_3; d1_4 <= d1_3;
      big4 <= (d0_3 >= d1_3) ? d0_3 : d1_3;
      s4 <= s3; t4 <= t3;
      d0_5 <= d0_4; d1_5 <= d1_4; k5 <= k_c;
      s5 <= s4; t5 <= t4;
      m0 <= MW'(d0_5 >> k5);
      m1 <= MW'(d1_5 >> k5);
      s6 <= s5; t6 <= t5;
      num7 <= m1 * m1;
      m0sq7 <= m0 * m0;
      s7 <= s6; t7 <= t6;
      num8 <= num7;
      den8 <= weno3_pkg::DEN_W'(num7) + (weno3_pkg::DEN_W'(m0sq7) << 1);
      s8 <= s7; t8 <= t7;
    end
  end

  assign prep_ge = weno3_pkg::DEN_W'(num8) >= den8;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid <= v8;
      chain[0].zero  <= den8 == '0;
      chain[0].den   <= den8;
      chain[0].r     <= prep_ge ? weno3_pkg::DEN_W'(num8) - den8 : weno3_pkg::DEN_W'(num8);
      chain[0].q     <= weno3_pkg::Q_W'(prep_ge);
      chain[0].s     <= s8;
      chain[0].t     <= t8;
    end
  end

  for (genvar g = 0; g < weno3_pkg::STEPS; g++) begin : g_div
    weno3_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (chain[g]),
      .o   (chain[g+1])
    );
  end

  assign q_inc = chain[weno3_pkg::STEPS].q + 1'b1;

  always_ff @(posedge clk) begin
    if (adv) begin
      w_reg <= chain[weno3_pkg::STEPS].zero ? weno3_pkg::W_ONE_THIRD
                                            : q_inc[weno3_pkg::Q_W-1:1];
      sw <= chain[weno3_pkg::STEPS].s;
      tw <= chain[weno3_pkg::STEPS].t;
      prod <= $signed({1'b0, w_reg}) * tw;
      sm <= sw;
    end
  end

  always_comb begin
    x_sum = (weno3_pkg::X_W'(sm) <<< weno3_pkg::W_BITS) + weno3_pkg::X_W'(prod)
          + (weno3_pkg::X_W'(1) <<< weno3_pkg::W_BITS);
    q_sh = x_sum >>> (weno3_pkg::W_BITS + 1);
    if (q_sh > weno3_pkg::X_W'(32'sh7FFFFFFF)) begin
      res = 32'sh7FFFFFFF;
    end else if (q_sh < -(weno3_pkg::X_W'(1) <<< (weno3_pkg::IN_W - 1))) begin
      res = 32'sh80000000;
    end else begin
      res = q_sh[weno3_pkg::IN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (vm && adv) begin
        skid_valid <= 1'b1;
        skid_data <= res;
      end
    end else if (skid_valid) begin
      out_valid <= 1'b1;
      fhat <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= vm;
      fhat <= res;
    end
  end
endmodule

@@ hdl/weno3_div_cell.sv @@
// One cell of the restoring divider chain: one quotient bit per cell.
// Depends on weno3_pkg.
`timescale 1ns / 1ps
module weno3_div_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  weno3_pkg::div_stage_t d,
  output weno3_pkg::div_stage_t o
);
  logic [weno3_pkg::DEN_W:0] r2;
  logic [weno3_pkg::DEN_W:0] rn;
  logic                      ge;
  weno3_pkg::div_stage_t     nxt;

  always_comb begin
    r2 = {d.r, 1'b0};
    ge = r2 >= {1'b0, d.den};
    rn = ge ? r2 - {1'b0, d.den} : r2;
    nxt = d;
    nxt.r = rn[weno3_pkg::DEN_W-1:0];
    nxt.q = {d.q[weno3_pkg::Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o.valid <= 1'b0;
    end else if (en) begin
      o <= nxt;
    end
  end
endmodule

@@ hdl/weno3_chk.sv @@
// Port checker for the WENO3 face reconstruction, bound to the top level.
// Depends on assert_macros.svh and weno3_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module weno3_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [weno3_pkg::IN_W-1:0]        fhat
);
  // A stalled result stays offered and unchanged.
  `ASSERT_RUN(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `ASSERT_RUN(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(fhat))
  // Reset empties the pipeline and the skid entry.
  `ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid && in_ready)
  // Input is refused only when a result is held back.
  `ASSERT_RUN(a_stall_cause, clk, rst, !in_ready |-> $past(out_valid && !out_ready))
endmodule

bind weno3_face_reconstruction weno3_chk u_weno3_chk (.*);
